@@ src/rigid_body_euler_step_unit_macros.svh @@
// Assertion macros for the rigid body Euler step unit.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef RIGID_BODY_EULER_STEP_UNIT_MACROS_SVH
`define RIGID_BODY_EULER_STEP_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rbe_pkg.sv @@
// Shared types, constants and helpers for the rigid body Euler step unit.
// No dependencies; design files refer to it by scoped names, test files import it.
package rbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int QUO_W     = 2 * DATA_W;
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = QUO_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [REG_W-1:0]         reg_val_t;
  typedef logic [1:0]               axis_t;

  localparam reg_val_t ONE_Q     = reg_val_t'(1) << FRAC_BITS;
  localparam word_t    WORD_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t    WORD_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam axis_t    AXIS_X    = 2'd0;
  localparam axis_t    AXIS_Y    = 2'd1;
  localparam axis_t    AXIS_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASS      = 4'd0,
    REG_INERTIA_X = 4'd1,
    REG_INERTIA_Y = 4'd2,
    REG_INERTIA_Z = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic  func;
    word_t force_x;
    word_t force_y;
    word_t force_z;
    word_t point_x;
    word_t point_y;
    word_t point_z;
  } rbe_in_t;

  typedef struct packed {
    word_t lin_vel_x;
    word_t lin_vel_y;
    word_t lin_vel_z;
    word_t ang_vel_x;
    word_t ang_vel_y;
    word_t ang_vel_z;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t orient_x;
    word_t orient_y;
    word_t orient_z;
  } rbe_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic  capture;
    logic  lin_load;
    logic  ang_load;
    logic  div_step;
    logic  lin_acc;
    logic  ang_acc;
    logic  mul_first;
    logic  mul_second;
    logic  integrate;
    logic  out_load;
    axis_t axis;
  } rbe_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;
  } rbe_status_t;

  // Signed add clamped to the word range.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? WORD_MIN : WORD_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

@@ src/rbe_if.sv @@
// Channel interfaces of the rigid body Euler step unit: input, result, config.
// Depends on rbe_pkg for widths and the word type.
interface rbe_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  rbe_pkg::word_t      force_x;
  rbe_pkg::word_t      force_y;
  rbe_pkg::word_t      force_z;
  rbe_pkg::word_t      point_x;
  rbe_pkg::word_t      point_y;
  rbe_pkg::word_t      point_z;
  modport source(output valid, func, force_x, force_y, force_z,
                 point_x, point_y, point_z, input ready);
  modport sink(input valid, func, force_x, force_y, force_z,
               point_x, point_y, point_z, output ready);
endinterface

interface rbe_out_if;
  logic           valid;
  logic           ready;
  rbe_pkg::word_t lin_vel_x;
  rbe_pkg::word_t lin_vel_y;
  rbe_pkg::word_t lin_vel_z;
  rbe_pkg::word_t ang_vel_x;
  rbe_pkg::word_t ang_vel_y;
  rbe_pkg::word_t ang_vel_z;
  rbe_pkg::word_t pos_x;
  rbe_pkg::word_t pos_y;
  rbe_pkg::word_t pos_z;
  rbe_pkg::word_t orient_x;
  rbe_pkg::word_t orient_y;
  rbe_pkg::word_t orient_z;
  modport source(output valid, lin_vel_x, lin_vel_y, lin_vel_z,
                 ang_vel_x, ang_vel_y, ang_vel_z, pos_x, pos_y, pos_z,
                 orient_x, orient_y, orient_z, input ready);
  modport sink(input valid, lin_vel_x, lin_vel_y, lin_vel_z,
               ang_vel_x, ang_vel_y, ang_vel_z, pos_x, pos_y, pos_z,
               orient_x, orient_y, orient_z, output ready);
endinterface

interface rbe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rbe_pkg::CFG_IDX_W-1:0] index;
  logic [rbe_pkg::DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/rbe_ctrl.sv @@
// Sequencing state machine for the rigid body Euler step unit.
// Depends on rbe_pkg for the command and status structs.
module rbe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 busy,
  input  rbe_pkg::rbe_status_t status,
  output rbe_pkg::rbe_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_LIN_LOAD = 10'b0000000010,
    S_DIV      = 10'b0000000100,
    S_LIN_ACC  = 10'b0000001000,
    S_MUL1     = 10'b0000010000,
    S_MUL2     = 10'b0000100000,
    S_ANG_LOAD = 10'b0001000000,
    S_ANG_ACC  = 10'b0010000000,
    S_INTEG    = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  state_t                state_r, state_nxt;
  rbe_pkg::axis_t        axis_r, axis_nxt;
  logic                  ang_phase_r, ang_phase_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign busy      = !in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    ang_phase_nxt = ang_phase_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = rbe_pkg::AXIS_X;
          state_nxt   = S_LIN_LOAD;
        end
      end
      S_LIN_LOAD: begin
        cmd.lin_load  = 1'b1;
        ang_phase_nxt = 1'b0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ang_phase_r ? S_ANG_ACC : S_LIN_ACC;
        end
      end
      S_LIN_ACC: begin
        cmd.lin_acc = 1'b1;
        if (axis_r == rbe_pkg::AXIS_LAST) begin
          axis_nxt  = rbe_pkg::AXIS_X;
          state_nxt = S_MUL1;
        end else begin
          axis_nxt  = axis_r + rbe_pkg::AXIS_Y;
          state_nxt = S_LIN_LOAD;
        end
      end
      S_MUL1: begin
        cmd.mul_first = 1'b1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_second = 1'b1;
        state_nxt      = S_ANG_LOAD;
      end
      S_ANG_LOAD: begin
        cmd.ang_load  = 1'b1;
        ang_phase_nxt = 1'b1;
        state_nxt     = S_DIV;
      end
      S_ANG_ACC: begin
        cmd.ang_acc = 1'b1;
        if (axis_r == rbe_pkg::AXIS_LAST) begin
          state_nxt = S_INTEG;
        end else begin
          axis_nxt  = axis_r + rbe_pkg::AXIS_Y;
          state_nxt = S_MUL1;
        end
      end
      S_INTEG: begin
        cmd.integrate = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // Wait for the result register to free up.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= rbe_pkg::AXIS_X;
      ang_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      ang_phase_r <= ang_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/rbe_datapath.sv @@
// Datapath of the rigid body Euler step unit: config registers, body state,
// shared multiplier and radix-4 serial divider. Depends on rbe_pkg.
module rbe_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rbe_pkg::rbe_cmd_t                cmd,
  output rbe_pkg::rbe_status_t             status,
  input  logic                             cfg_we,
  input  logic [rbe_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rbe_pkg::DATA_W-1:0]       cfg_data,
  input  rbe_pkg::rbe_in_t                 in_data,
  output rbe_pkg::rbe_out_t                out_data
);

  // Configuration
  rbe_pkg::reg_val_t mass_r;
  rbe_pkg::reg_val_t inertia_r [3];

  // Captured transaction
  logic           func_r;
  rbe_pkg::word_t force_r [3];
  rbe_pkg::word_t point_r [3];

  // Body state
  rbe_pkg::word_t lv_r  [3];
  rbe_pkg::word_t av_r  [3];
  rbe_pkg::word_t pos_r [3];
  rbe_pkg::word_t ori_r [3];

  // Multiplier
  logic signed [rbe_pkg::PROD_W-1:0] prod_r, p1_r, mul_p;
  rbe_pkg::word_t op_a, op_b, op_c, op_d, mul_x, mul_y;

  // Divider
  rbe_pkg::reg_val_t                dvs_r, rem_r, rem_nxt;
  logic [rbe_pkg::QUO_W-1:0]        quo_r, quo_nxt;
  logic                             neg_r;
  logic [rbe_pkg::DIV_CNT_W-1:0]    cnt_r;

  rbe_pkg::word_t    f_sel, lv_sel, av_sel, div_res;
  rbe_pkg::reg_val_t inertia_sel;
  logic [rbe_pkg::DATA_W-1:0] f_mag;
  logic [rbe_pkg::QUO_W-1:0]  diff_pos, diff_neg;
  logic                       prod_ge;

  rbe_pkg::rbe_out_t out_r;

  assign out_data        = out_r;
  assign status.div_last = (cnt_r == rbe_pkg::DIV_CNT_W'(rbe_pkg::DIV_STEPS - 1));

  // Per-axis operand selection. Torque axis k uses p[k+1]*f[k+2] - p[k+2]*f[k+1].
  always_comb begin
    case (cmd.axis)
      rbe_pkg::AXIS_X: begin
        f_sel = force_r[0]; lv_sel = lv_r[0]; av_sel = av_r[0];
        inertia_sel = inertia_r[0];
        op_a = point_r[1]; op_b = force_r[2]; op_c = point_r[2]; op_d = force_r[1];
      end
      rbe_pkg::AXIS_Y: begin
        f_sel = force_r[1]; lv_sel = lv_r[1]; av_sel = av_r[1];
        inertia_sel = inertia_r[1];
        op_a = point_r[2]; op_b = force_r[0]; op_c = point_r[0]; op_d = force_r[2];
      end
      default: begin
        f_sel = force_r[2]; lv_sel = lv_r[2]; av_sel = av_r[2];
        inertia_sel = inertia_r[2];
        op_a = point_r[0]; op_b = force_r[1]; op_c = point_r[1]; op_d = force_r[0];
      end
    endcase
  end

  assign mul_x = cmd.mul_first ? op_a : op_c;
  assign mul_y = cmd.mul_first ? op_b : op_d;
  // Signed 32 by 32 product, operands sign-extended to the product width.
  assign mul_p = rbe_pkg::PROD_W'(mul_x) * rbe_pkg::PROD_W'(mul_y);

  assign f_mag    = f_sel[rbe_pkg::DATA_W-1] ? -f_sel : f_sel;
  assign prod_ge  = (p1_r >= prod_r);
  assign diff_pos = p1_r - prod_r;
  assign diff_neg = prod_r - p1_r;

  // Two restoring division steps per cycle.
  always_comb begin
    logic [rbe_pkg::REG_W:0] sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < rbe_pkg::DIV_BITS_PER_STEP; k++) begin
      sh      = {rem_nxt, quo_nxt[rbe_pkg::QUO_W-1]};
      quo_nxt = {quo_nxt[rbe_pkg::QUO_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs_r}) begin
        sh         = sh - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = sh[rbe_pkg::REG_W-1:0];
    end
  end

  // Zero divisor gives zero; otherwise clamp the quotient and apply the sign.
  always_comb begin
    if (dvs_r == '0) begin
      div_res = '0;
    end else if (|quo_r[rbe_pkg::QUO_W-1:rbe_pkg::DATA_W-1]) begin
      div_res = neg_r ? rbe_pkg::WORD_MIN : rbe_pkg::WORD_MAX;
    end else if (neg_r) begin
      div_res = -rbe_pkg::word_t'(quo_r[rbe_pkg::DATA_W-1:0]);
    end else begin
      div_res = rbe_pkg::word_t'(quo_r[rbe_pkg::DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= rbe_pkg::ONE_Q;
      for (int i = 0; i < 3; i++) begin
        inertia_r[i] <= rbe_pkg::ONE_Q;
      end
    end else if (cfg_we) begin
      case (rbe_pkg::cfg_reg_t'(cfg_idx))
        rbe_pkg::REG_MASS:      mass_r       <= cfg_data[rbe_pkg::REG_W-1:0];
        rbe_pkg::REG_INERTIA_X: inertia_r[0] <= cfg_data[rbe_pkg::REG_W-1:0];
        rbe_pkg::REG_INERTIA_Y: inertia_r[1] <= cfg_data[rbe_pkg::REG_W-1:0];
        rbe_pkg::REG_INERTIA_Z: inertia_r[2] <= cfg_data[rbe_pkg::REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lv_r[i]  <= '0;
        av_r[i]  <= '0;
        pos_r[i] <= '0;
        ori_r[i] <= '0;
      end
    end else begin
      if (cmd.lin_acc) begin
        lv_r[cmd.axis] <= rbe_pkg::sat_add(lv_sel, div_res);
      end
      if (cmd.ang_acc) begin
        av_r[cmd.axis] <= rbe_pkg::sat_add(av_sel, div_res);
      end
      if (cmd.integrate && func_r) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= rbe_pkg::sat_add(pos_r[i], lv_r[i]);
          ori_r[i] <= rbe_pkg::sat_add(ori_r[i], av_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_data.func;
      force_r[0] <= in_data.force_x;
      force_r[1] <= in_data.force_y;
      force_r[2] <= in_data.force_z;
      point_r[0] <= in_data.point_x;
      point_r[1] <= in_data.point_y;
      point_r[2] <= in_data.point_z;
    end
    if (cmd.mul_first) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_second) begin
      p1_r   <= prod_r;
      prod_r <= mul_p;
    end
    if (cmd.lin_load) begin
      quo_r <= rbe_pkg::QUO_W'(f_mag) << rbe_pkg::FRAC_BITS;
      rem_r <= '0;
      dvs_r <= mass_r;
      neg_r <= f_sel[rbe_pkg::DATA_W-1];
      cnt_r <= '0;
    end else if (cmd.ang_load) begin
      quo_r <= prod_ge ? diff_pos : diff_neg;
      rem_r <= '0;
      dvs_r <= inertia_sel;
      neg_r <= !prod_ge;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_r.lin_vel_x <= lv_r[0];
      out_r.lin_vel_y <= lv_r[1];
      out_r.lin_vel_z <= lv_r[2];
      out_r.ang_vel_x <= av_r[0];
      out_r.ang_vel_y <= av_r[1];
      out_r.ang_vel_z <= av_r[2];
      out_r.pos_x     <= pos_r[0];
      out_r.pos_y     <= pos_r[1];
      out_r.pos_z     <= pos_r[2];
      out_r.orient_x  <= ori_r[0];
      out_r.orient_y  <= ori_r[1];
      out_r.orient_z  <= ori_r[2];
    end
  end

endmodule

@@ src/rigid_body_euler_step_unit.sv @@
// Top level of the rigid body Euler step unit: controller plus datapath.
// Depends on rbe_pkg, rbe_if, rbe_ctrl, rbe_datapath and the macros header.
//
//   channel | dir | payload                                    | handshake
//   --------+-----+--------------------------------------------+-------------
//   in_ch   | in  | func, force_x/y/z, point_x/y/z             | valid/ready
//   out_ch  | out | lin_vel, ang_vel, pos, orient (x/y/z each) | valid/ready
//   cfg_ch  | in  | index, data (mass, inertia_x/y/z)          | valid/ready
//
// A transaction's result is valid after six divisions on the shared divider (two
// quotient bits a cycle, 64-bit dividend), a load and an accumulate state around
// each, the MUL1 and MUL2 multiplier states per torque axis, then the integrate
// and output states. Input is taken only in idle, so a new transaction waits until
// the last is through; a held result stalls the next transaction in its output state.
// Sync active-low reset zeroes the state, config to 1.0; config always ready.
`include "rigid_body_euler_step_unit_macros.svh"

module rigid_body_euler_step_unit (
  input logic       clk,
  input logic       rst_n,
  rbe_in_if.sink    in_ch,
  rbe_out_if.source out_ch,
  rbe_cfg_if.sink   cfg_ch
);

  rbe_pkg::rbe_cmd_t    cmd;
  rbe_pkg::rbe_status_t status;
  rbe_pkg::rbe_in_t     in_data;
  rbe_pkg::rbe_out_t    out_data;
  logic                 in_ready_w;
  logic                 out_valid_w;
  logic                 busy;
  logic                 in_fire;

  // Pack the input channel into one payload word for the datapath.
  assign in_data.func    = in_ch.func;
  assign in_data.force_x = in_ch.force_x;
  assign in_data.force_y = in_ch.force_y;
  assign in_data.force_z = in_ch.force_z;
  assign in_data.point_x = in_ch.point_x;
  assign in_data.point_y = in_ch.point_y;
  assign in_data.point_z = in_ch.point_z;

  assign in_ch.ready = in_ready_w;
  assign in_fire     = in_ch.valid && in_ready_w;

  // Config registers accept a write every cycle.
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_w;
  assign out_ch.lin_vel_x = out_data.lin_vel_x;
  assign out_ch.lin_vel_y = out_data.lin_vel_y;
  assign out_ch.lin_vel_z = out_data.lin_vel_z;
  assign out_ch.ang_vel_x = out_data.ang_vel_x;
  assign out_ch.ang_vel_y = out_data.ang_vel_y;
  assign out_ch.ang_vel_z = out_data.ang_vel_z;
  assign out_ch.pos_x     = out_data.pos_x;
  assign out_ch.pos_y     = out_data.pos_y;
  assign out_ch.pos_z     = out_data.pos_z;
  assign out_ch.orient_x  = out_data.orient_x;
  assign out_ch.orient_y  = out_data.orient_y;
  assign out_ch.orient_z  = out_data.orient_z;

  // Sequence: linear x/y/z divisions, then per axis two products and one
  // division for the torque, then the position/orientation update when func is set.
  rbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready_w),
    .out_ready (out_ch.ready),
    .out_valid (out_valid_w),
    .busy      (busy),
    .status    (status),
    .cmd       (cmd)
  );

  rbe_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // Accepting a transaction must take the unit out of idle.
  `RBE_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready, "accepted while still idle")
  // A new result appears only at the end of a transaction's work.
  `RBE_ASSERT_NOW(a_result_from_work, $rose(out_valid_w), $past(busy), "result without work")
  // The controller returns to idle the cycle the result is posted.
  `RBE_ASSERT_NOW(a_idle_on_result, $rose(out_valid_w), in_ready_w, "not idle after result")

endmodule

@@ verif/rigid_body_euler_step_unit_test_pkg.sv @@
// Scoreboard for the rigid body Euler step unit test: a cycle-free predictor of
// the body state plus the store of expected results. Depends on rbe_pkg only.
package rbe_step_check_pkg;
  import rbe_pkg::*;

  class body_step_checker;
    reg_val_t    mass;
    reg_val_t    inertia[3];
    word_t       lin_vel[3];
    word_t       ang_vel[3];
    word_t       pos[3];
    word_t       orient[3];
    rbe_out_t    expected_states[$];
    int unsigned errors;

    function new();
      mass = ONE_Q;
      foreach (inertia[i]) begin
        inertia[i] = ONE_Q;
        lin_vel[i] = '0;
        ang_vel[i] = '0;
        pos[i]     = '0;
        orient[i]  = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    // Bits above the register width are dropped; unknown indexes do nothing.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      reg_val_t v;
      v = data[REG_W-1:0];
      case (idx)
        REG_MASS:      mass = v;
        REG_INERTIA_X: inertia[0] = v;
        REG_INERTIA_Y: inertia[1] = v;
        REG_INERTIA_Z: inertia[2] = v;
        default: ;
      endcase
    endfunction

    static function word_t add_clamped(word_t a, word_t b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(WORD_MAX)) return WORD_MAX;
      if (s < longint'(WORD_MIN)) return WORD_MIN;
      return s[DATA_W-1:0];
    endfunction

    // Truncating divide of sign and magnitude, clamped; a zero divisor gives zero.
    static function word_t quotient_clamped(bit neg, logic [63:0] mag, reg_val_t divisor);
      logic [63:0] q;
      if (divisor == 0) return '0;
      q = mag / 64'(divisor);
      if (neg) begin
        if (q >= 64'h8000_0000) return WORD_MIN;
        return word_t'(-q[DATA_W-1:0]);
      end
      if (q > 64'h7FFF_FFFF) return WORD_MAX;
      return q[DATA_W-1:0];
    endfunction

    // (a*b - c*d) / divisor, difference kept exact at double fraction width.
    static function word_t torque_accel(word_t a, word_t b, word_t c, word_t d,
                                        reg_val_t divisor);
      longint p1;
      longint p2;
      logic [63:0] diff;
      p1 = longint'(a) * longint'(b);
      p2 = longint'(c) * longint'(d);
      if (p1 >= p2) begin
        diff = p1 - p2;
        return quotient_clamped(1'b0, diff, divisor);
      end
      diff = p2 - p1;
      return quotient_clamped(1'b1, diff, divisor);
    endfunction

    function void note_tick(rbe_in_t t);
      word_t       f[3];
      word_t       p[3];
      logic [63:0] mag;
      rbe_out_t    s;
      f = '{t.force_x, t.force_y, t.force_z};
      p = '{t.point_x, t.point_y, t.point_z};
      for (int i = 0; i < 3; i++) begin
        mag = (f[i] < 0) ? 64'(-longint'(f[i])) : 64'(longint'(f[i]));
        lin_vel[i] = add_clamped(lin_vel[i],
                                 quotient_clamped(f[i] < 0, mag << FRAC_BITS, mass));
      end
      ang_vel[0] = add_clamped(ang_vel[0], torque_accel(p[1], f[2], p[2], f[1], inertia[0]));
      ang_vel[1] = add_clamped(ang_vel[1], torque_accel(p[2], f[0], p[0], f[2], inertia[1]));
      ang_vel[2] = add_clamped(ang_vel[2], torque_accel(p[0], f[1], p[1], f[0], inertia[2]));
      if (t.func) begin
        for (int i = 0; i < 3; i++) begin
          pos[i]    = add_clamped(pos[i], lin_vel[i]);
          orient[i] = add_clamped(orient[i], ang_vel[i]);
        end
      end
      s = '{lin_vel[0], lin_vel[1], lin_vel[2], ang_vel[0], ang_vel[1], ang_vel[2],
            pos[0], pos[1], pos[2], orient[0], orient[1], orient[2]};
      expected_states.push_back(s);
    endfunction

    function void check_field(string name, word_t want, word_t got);
      if (want !== got) begin
        $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name, want, want, got, got);
        errors++;
      end
    endfunction

    function void check_state(rbe_out_t got);
      rbe_out_t want;
      if (expected_states.size() == 0) begin
        $error("result transaction with no input transaction waiting for it");
        errors++;
        return;
      end
      want = expected_states.pop_front();
      check_field("lin_vel_x", want.lin_vel_x, got.lin_vel_x);
      check_field("lin_vel_y", want.lin_vel_y, got.lin_vel_y);
      check_field("lin_vel_z", want.lin_vel_z, got.lin_vel_z);
      check_field("ang_vel_x", want.ang_vel_x, got.ang_vel_x);
      check_field("ang_vel_y", want.ang_vel_y, got.ang_vel_y);
      check_field("ang_vel_z", want.ang_vel_z, got.ang_vel_z);
      check_field("pos_x", want.pos_x, got.pos_x);
      check_field("pos_y", want.pos_y, got.pos_y);
      check_field("pos_z", want.pos_z, got.pos_z);
      check_field("orient_x", want.orient_x, got.orient_x);
      check_field("orient_y", want.orient_y, got.orient_y);
      check_field("orient_z", want.orient_z, got.orient_z);
    endfunction
  endclass

endpackage

@@ verif/rigid_body_euler_step_unit_test.sv @@
// Top of the rigid body Euler step unit test: clock, reset, stimulus, monitors.
// Depends on rbe_pkg, the rbe_if channel interfaces, rbe_step_check_pkg and the
// unit itself.
module rigid_body_euler_step_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbe_pkg::*;
  import rbe_step_check_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned TICKS_PER_PHASE = 305;
  // Wait after the final drain; leave margin for the tail.
  localparam int unsigned SETTLE_CYCLES   = 250;
  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int          SMALL_SPAN      = 1 << 18;
  localparam word_t       Q_ONE           = 32'sh0001_0000;
  localparam int unsigned FIRST_UNUSED_REG = int'(REG_INERTIA_Z) + 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rbe_in_if  in_ch();
  rbe_out_if out_ch();
  rbe_cfg_if cfg_ch();

  rigid_body_euler_step_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  body_step_checker body_model = new();
  bit               idling_on  = 1'b1;
  int unsigned      hold_left  = 0;
  int unsigned      quiet_cycles = 0;

  always #5 clk = ~clk;

  // Monitors: every handshake is sampled at the rising edge, before the unit's
  // own registers move. Config writes, accepted inputs and results all feed the
  // scoreboard in edge order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        body_model.write_reg(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        body_model.note_tick('{in_ch.func, in_ch.force_x, in_ch.force_y, in_ch.force_z,
                               in_ch.point_x, in_ch.point_y, in_ch.point_z});
      end
      if (out_ch.valid && out_ch.ready) begin
        body_model.check_state('{out_ch.lin_vel_x, out_ch.lin_vel_y, out_ch.lin_vel_z,
                                 out_ch.ang_vel_x, out_ch.ang_vel_y, out_ch.ang_vel_z,
                                 out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                                 out_ch.orient_x, out_ch.orient_y, out_ch.orient_z});
      end
    end
  end

  // Result side: hold ready low in bursts of random length while idling is on,
  // otherwise keep it high. Changes land on the falling edge.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 8) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which no transaction moves on any channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rigid_body_euler_step_unit test failed");
      $finish;
    end
  end

  function automatic rbe_in_t make_tick(bit func, word_t fx, word_t fy, word_t fz,
                                        word_t px, word_t py, word_t pz);
    return '{func, fx, fy, fz, px, py, pz};
  endfunction

  // Mostly small signed values around zero; wild picks hit the rails, zero or
  // a full-width random word.
  function automatic word_t pick_word(bit wild);
    int v;
    if (wild) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return $urandom;
      endcase
    end
    v = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
    return v;
  endfunction

  function automatic rbe_in_t random_tick();
    rbe_in_t     t;
    int unsigned mode;
    mode      = $urandom_range(0, 15);
    t.func    = 1'($urandom_range(0, 1));
    t.force_x = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    t.force_y = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    t.force_z = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    t.point_x = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    t.point_y = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    t.point_z = (mode == 0) ? word_t'($urandom) : pick_word(mode == 1);
    return t;
  endfunction

  // Register values: zero, the smallest and largest settings, a word with the
  // dropped top bit set, full random, or something near 1.0.
  function automatic logic [DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // Drive one input transaction and wait for its handshake; maybe drop valid
  // for a random burst afterwards.
  task automatic send_tick(input rbe_in_t t);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= t.func;
    in_ch.force_x <= t.force_x;
    in_ch.force_y <= t.force_y;
    in_ch.force_z <= t.force_z;
    in_ch.point_x <= t.point_x;
    in_ch.point_y <= t.point_y;
    in_ch.point_z <= t.point_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the input side until every expected result has come back.
  task automatic drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (body_model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Reprogram all four registers once the unit is idle; a stray write to an
  // index past the last register is optionally tacked on and must do nothing.
  task automatic program_body(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] ix,
                              input logic [DATA_W-1:0] iy, input logic [DATA_W-1:0] iz,
                              input bit stray);
    drain();
    cfg_write(REG_MASS, m);
    cfg_write(REG_INERTIA_X, ix);
    cfg_write(REG_INERTIA_Y, iy);
    cfg_write(REG_INERTIA_Z, iz);
    if (stray) begin
      cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, (1 << CFG_IDX_W) - 1)), $urandom);
    end
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    in_ch.valid   = 1'b0;
    in_ch.func    = 1'b0;
    in_ch.force_x = '0;
    in_ch.force_y = '0;
    in_ch.force_z = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: reset configuration (all 1.0) first, then rail values on every
    // field, zero mass, zero inertia on each axis, dropped top register bit.
    send_tick(make_tick(1'b0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, Q_ONE, -2 * Q_ONE, 3 * Q_ONE, Q_ONE, 2 * Q_ONE, -3 * Q_ONE));
    send_tick(make_tick(1'b1, -1, -1, -1, 1, 1, 1));
    send_tick(make_tick(1'b1, WORD_MAX, WORD_MIN, 0, 0, 0, 0));
    send_tick(make_tick(1'b1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN));
    send_tick(make_tick(1'b0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_tick(make_tick(1'b1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN));
    send_tick(make_tick(1'b1, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));

    // Zero mass and zero inertia about x: those accelerations must vanish.
    program_body(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1, 1'b1);
    send_tick(make_tick(1'b1, WORD_MAX, 3 * Q_ONE, WORD_MIN, Q_ONE, WORD_MIN, 5));
    send_tick(make_tick(1'b0, 7, -7, 123456, -Q_ONE, 77, WORD_MAX));
    send_tick(make_tick(1'b1, -3, 3, -3, 3, -3, 3));

    // Top bit of each write is dropped: mass lands on the largest value.
    program_body(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h8000_0003, 1'b1);
    send_tick(make_tick(1'b1, WORD_MIN, WORD_MAX, 5 * Q_ONE, WORD_MAX, -Q_ONE, WORD_MIN));
    send_tick(make_tick(1'b1, Q_ONE, -Q_ONE, 1, 2 * Q_ONE, 3 * Q_ONE, -4 * Q_ONE));
    send_tick(make_tick(1'b0, -Q_ONE, 0, WORD_MAX, 0, WORD_MIN, Q_ONE));

    // Smallest nonzero mass, zero inertia about z.
    program_body(32'd1, 32'h7FFF_FFFF, 32'd1, 32'd0, 1'b0);
    send_tick(make_tick(1'b1, 1, -1, 2, WORD_MIN, WORD_MAX, 1));
    send_tick(make_tick(1'b1, WORD_MIN, 0, -2, 3, Q_ONE, -Q_ONE));
    send_tick(make_tick(1'b0, 0, WORD_MAX, 0, WORD_MAX, 0, WORD_MIN));

    program_body(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b0);
    send_tick(make_tick(1'b1, Q_ONE / 2, -Q_ONE / 3, 12345, -678, 9, Q_ONE * 7));

    // Random phases, each under a fresh setting. The last one runs without
    // idling on either side; the third pauses halfway until all results drain.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_body(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
                   1'($urandom_range(0, 1)));
      idling_on = (ph != RANDOM_PHASES - 1);
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        if (ph == 2 && n == TICKS_PER_PHASE / 2) begin
          drain();
        end
        send_tick(random_tick());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (body_model.pending() != 0) begin
      $error("%0d expected results never arrived", body_model.pending());
      body_model.errors++;
    end
    if (body_model.errors == 0) begin
      $display("rigid_body_euler_step_unit test passed");
    end else begin
      $display("rigid_body_euler_step_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/rbe_pkg.sv
src/rbe_if.sv
src/rbe_ctrl.sv
src/rbe_datapath.sv
src/rigid_body_euler_step_unit.sv
verif/rigid_body_euler_step_unit_test_pkg.sv
verif/rigid_body_euler_step_unit_test.sv
